@@ design/tmss_pkg.sv @@
// Shared types, step tables and helpers for the timed motion step sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tmss_pkg;

    // Default tick rate of the real-time counter
    localparam int unsigned TPS_DEFAULT = 32768;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned MOTOR_W  = 17;
    localparam int unsigned DIR_W    = 10;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned LIGHT_POS = 16;

    // Sequence lengths
    localparam int unsigned MAIN_LEN   = 14;
    localparam int unsigned FOLD_LEN   = 5;
    localparam int unsigned UNFOLD_LEN = 4;
    localparam int unsigned MAX_MS     = 4500;

    // Step durations in milliseconds
    localparam int unsigned MAIN_MS [MAIN_LEN] = '{
        1000, 1400, 1900, 1600, 3000, 1400, 1000,
        1400, 4475, 1600,   50,  125, 1600, 1400
    };
    localparam int unsigned FOLD_MS [FOLD_LEN] = '{0, 100, 4500, 200, 800};
    localparam int unsigned UNFOLD_MS [UNFOLD_LEN] = '{0, 200, 850, 4500};

    // Motor direction masks for each step
    localparam logic [DIR_W-1:0] MAIN_DIR [MAIN_LEN] = '{
        10'h000, 10'h001, 10'h004, 10'h1A4, 10'h100, 10'h002, 10'h000,
        10'h001, 10'h200, 10'h058, 10'h040, 10'h010, 10'h008, 10'h002
    };
    localparam logic [DIR_W-1:0] FOLD_DIR [FOLD_LEN] = '{
        10'h000, 10'h002, 10'h068, 10'h020, 10'h040
    };
    localparam logic [DIR_W-1:0] UNFOLD_DIR [UNFOLD_LEN] = '{
        10'h000, 10'h010, 10'h080, 10'h094
    };

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_FOLD   = 3'd3,
        CMD_UNFOLD = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_START_REQ = 3'd0,
        MODE_STARTED   = 3'd1,
        MODE_STOP_REQ  = 3'd2,
        MODE_STOPPED   = 3'd3,
        MODE_FOLD      = 3'd4,
        MODE_UNFOLD    = 3'd5
    } t_mode;

    // One input beat
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] time_now;
    } t_item;

    // Result of processing one beat
    typedef struct packed {
        logic               fire;
        logic [MOTOR_W-1:0] motor_command;
    } t_result;

endpackage

@@ design/tmss_in_reg.sv @@
// Input register of the sequencer: captures one beat and holds it until the
// core consumes it. Depends on tmss_pkg.
`timescale 1ns / 1ps

module tmss_in_reg
    import tmss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Stall while a held beat cannot move on
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Load a new beat whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

@@ design/tmss_core.sv @@
// Sequencer core: mode, step index and deadline registers plus the step
// logic for one beat. Depends on tmss_pkg.
`timescale 1ns / 1ps

module tmss_core
    import tmss_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TPS_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    output t_result o_result
);

    localparam longint unsigned MAX_TICKS =
        64'(MAX_MS) * 64'(TICKS_PER_SECOND) / 64'd1000;
    localparam int unsigned TICKS_W = $clog2(MAX_TICKS + 64'd1);

    t_mode              r_mode,     n_mode;
    logic [STEP_W-1:0]  r_step,     n_step;
    logic [TIME_W-1:0]  r_deadline, n_deadline;

    logic [TICKS_W-1:0] main_ticks   [MAIN_LEN];
    logic [TICKS_W-1:0] fold_ticks   [FOLD_LEN];
    logic [TICKS_W-1:0] unfold_ticks [UNFOLD_LEN];

    logic [STEP_W:0]    step_inc;
    logic [STEP_W:0]    main_wrap;
    logic [STEP_W:0]    fold_wrap;
    logic [STEP_W-1:0]  main_next;
    logic [2:0]         fold_next;
    logic [1:0]         unfold_next;
    logic [STEP_W-1:0]  sel_next;
    logic [TICKS_W-1:0] sel_ticks;
    logic [DIR_W-1:0]   sel_dir;
    logic               late;
    logic [TIME_W-1:0]  new_deadline;
    t_cmd               cmd;

    // Scale durations to ticks at elaboration
    for (genvar g = 0; g < MAIN_LEN; g++) begin : g_main
        assign main_ticks[g] =
            TICKS_W'(64'(MAIN_MS[g]) * 64'(TICKS_PER_SECOND) / 64'd1000);
    end
    for (genvar g = 0; g < FOLD_LEN; g++) begin : g_fold
        assign fold_ticks[g] =
            TICKS_W'(64'(FOLD_MS[g]) * 64'(TICKS_PER_SECOND) / 64'd1000);
    end
    for (genvar g = 0; g < UNFOLD_LEN; g++) begin : g_unfold
        assign unfold_ticks[g] =
            TICKS_W'(64'(UNFOLD_MS[g]) * 64'(TICKS_PER_SECOND) / 64'd1000);
    end

    // Next step index for each sequence, wrapped at its length
    assign step_inc = {1'b0, r_step} + 5'd1;
    assign main_wrap = (step_inc >= 5'(MAIN_LEN)) ? step_inc - 5'(MAIN_LEN) : step_inc;
    assign main_next = main_wrap[STEP_W-1:0];

    always_comb begin
        if (step_inc >= 5'(3 * FOLD_LEN)) begin
            fold_wrap = step_inc - 5'(3 * FOLD_LEN);
        end else if (step_inc >= 5'(2 * FOLD_LEN)) begin
            fold_wrap = step_inc - 5'(2 * FOLD_LEN);
        end else if (step_inc >= 5'(FOLD_LEN)) begin
            fold_wrap = step_inc - 5'(FOLD_LEN);
        end else begin
            fold_wrap = step_inc;
        end
    end
    assign fold_next   = fold_wrap[2:0];
    assign unfold_next = step_inc[1:0];

    // Pick the table of the running sequence
    always_comb begin
        case (r_mode)
            MODE_FOLD: begin
                sel_next  = STEP_W'(fold_next);
                sel_ticks = fold_ticks[fold_next];
                sel_dir   = FOLD_DIR[fold_next];
            end
            MODE_UNFOLD: begin
                sel_next  = STEP_W'(unfold_next);
                sel_ticks = unfold_ticks[unfold_next];
                sel_dir   = UNFOLD_DIR[unfold_next];
            end
            default: begin
                sel_next  = main_next;
                sel_ticks = main_ticks[main_next];
                sel_dir   = MAIN_DIR[main_next];
            end
        endcase
    end

    assign late         = i_item.time_now > r_deadline;
    assign new_deadline = i_item.time_now + TIME_W'(sel_ticks);
    assign cmd          = t_cmd'(i_item.cmd);

    // Work out the next state and the result of the beat
    always_comb begin
        n_mode     = r_mode;
        n_step     = r_step;
        n_deadline = r_deadline;
        o_result   = '0;
        if (i_go) begin
            case (cmd)
                CMD_START: begin
                    if (r_mode == MODE_STOPPED) begin
                        n_mode = MODE_START_REQ;
                    end
                end
                CMD_STOP: begin
                    if (r_mode == MODE_STARTED) begin
                        n_mode = MODE_STOP_REQ;
                    end
                end
                CMD_FOLD, CMD_UNFOLD: begin
                    if (r_mode == MODE_STOPPED) begin
                        n_mode     = (cmd == CMD_FOLD) ? MODE_FOLD : MODE_UNFOLD;
                        n_step     = '0;
                        n_deadline = '0;
                    end
                end
                CMD_TICK: begin
                    case (r_mode)
                        MODE_START_REQ: begin
                            n_step     = '0;
                            n_deadline = '0;
                            n_mode     = MODE_STARTED;
                        end
                        MODE_STARTED, MODE_STOP_REQ: begin
                            if (late) begin
                                n_step     = sel_next;
                                n_deadline = new_deadline;
                                o_result.fire = 1'b1;
                                o_result.motor_command = MOTOR_W'(sel_dir);
                                o_result.motor_command[LIGHT_POS] =
                                    (r_mode == MODE_STARTED);
                            end
                            // Stopping ends once the main loop is back at step zero
                            if (r_mode == MODE_STOP_REQ && n_step == '0) begin
                                n_mode = MODE_STOPPED;
                            end
                        end
                        MODE_FOLD, MODE_UNFOLD: begin
                            if (late) begin
                                n_step     = sel_next;
                                n_deadline = new_deadline;
                                o_result.fire = 1'b1;
                                o_result.motor_command = MOTOR_W'(sel_dir);
                                if (sel_next == '0) begin
                                    n_mode = MODE_STOPPED;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_STOPPED;
            r_step     <= '0;
            r_deadline <= '0;
        end else begin
            r_mode     <= n_mode;
            r_step     <= n_step;
            r_deadline <= n_deadline;
        end
    end

endmodule

@@ design/tmss_out_reg.sv @@
// Output register of the sequencer: holds one motor command beat until the
// receiver takes it. Depends on tmss_pkg.
`timescale 1ns / 1ps

module tmss_out_reg
    import tmss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_result            i_result,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output logic [MOTOR_W-1:0] o_motor_command
);

    logic               r_valid;
    logic [MOTOR_W-1:0] r_command;

    // The slot can take a new beat if empty or being drained
    assign o_free          = !r_valid || !i_stall;
    assign o_valid         = r_valid;
    assign o_motor_command = r_command;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.fire) begin
            r_command <= i_result.motor_command;
        end
    end

endmodule

@@ design/timed_motion_step_sequencer_unit.sv @@
// Top level of the timed motion step sequencer.
// Depends on tmss_pkg, tmss_in_reg, tmss_core and tmss_out_reg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_valid / o_stall) carries one beat of i_cmd and
//   i_time_now: tick, start request, stop request, fold or unfold. A beat is
//   taken at a clock edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall) carries o_motor_command, produced only
//   by ticks whose time is strictly past the current deadline. Requests and
//   early ticks give no output beat.
//   Each beat goes from the input register through the step logic to the
//   output register. Throughput: one beat per cycle unless the receiver
//   stalls; the step logic is a single 64-bit compare and add plus a table
//   read between the input and output registers. When the receiver stalls,
//   the output beat holds; the input register keeps accepting until it
//   holds a beat that cannot move, then o_stall rises.
//   Reset (i_rst_n low at a clock edge) empties both registers and puts the
//   sequencer in the stopped mode at step zero with a zero deadline.
module timed_motion_step_sequencer_unit
    import tmss_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = TPS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [TIME_W-1:0]  i_time_now,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [MOTOR_W-1:0] o_motor_command
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    go;
    t_result result;

    assign in_item.cmd      = i_cmd;
    assign in_item.time_now = i_time_now;

    // Process the held beat when the output slot can take its result
    assign go = held_valid && out_free;

    tmss_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (out_free),
        .o_stall (o_stall),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    tmss_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (held_item),
        .o_result (result)
    );

    tmss_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_result        (result),
        .i_stall         (i_stall),
        .o_free          (out_free),
        .o_valid         (o_valid),
        .o_motor_command (o_motor_command)
    );

endmodule

@@ bench/timed_motion_step_sequencer_unit_tb.sv @@
// Self-checking bench for timed_motion_step_sequencer_unit: random valid/stall
// traffic on both channels, motor commands checked against an in-bench step model.
// Depends on tmss_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module timed_motion_step_sequencer_unit_tb;
    import tmss_pkg::*;

    localparam int unsigned TICK_RATE      = 32768;
    localparam int unsigned MAIN_STEPS     = 14;
    localparam int unsigned FOLD_STEPS     = 5;
    localparam int unsigned UNFOLD_STEPS   = 4;
    localparam int unsigned LIGHT_BIT      = 16;
    localparam int unsigned RANDOM_BEATS   = 900;
    localparam int unsigned TAIL_BEATS     = 150;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SHOW_LIMIT     = 10;
    // cmd codes the block does not define
    localparam int unsigned CMD_SPARE_LO   = 5;
    localparam int unsigned CMD_SPARE_HI   = 7;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Step tables: duration in ms and motor direction mask
    localparam int unsigned MAIN_STEP_MS [MAIN_STEPS] = '{
        1000, 1400, 1900, 1600, 3000, 1400, 1000,
        1400, 4475, 1600,   50,  125, 1600, 1400
    };
    localparam logic [9:0] MAIN_STEP_DIR [MAIN_STEPS] = '{
        10'h000, 10'h001, 10'h004, 10'h1A4, 10'h100, 10'h002, 10'h000,
        10'h001, 10'h200, 10'h058, 10'h040, 10'h010, 10'h008, 10'h002
    };
    localparam int unsigned FOLD_STEP_MS [FOLD_STEPS] = '{0, 100, 4500, 200, 800};
    localparam logic [9:0] FOLD_STEP_DIR [FOLD_STEPS] = '{
        10'h000, 10'h002, 10'h068, 10'h020, 10'h040
    };
    localparam int unsigned UNFOLD_STEP_MS [UNFOLD_STEPS] = '{0, 200, 850, 4500};
    localparam logic [9:0] UNFOLD_STEP_DIR [UNFOLD_STEPS] = '{
        10'h000, 10'h010, 10'h080, 10'h094
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_cmd = '0;
    logic [TIME_W-1:0]  i_time_now = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [MOTOR_W-1:0] o_motor_command;

    // Sequencer state as predicted
    t_mode               seq_mode = MODE_STOPPED;
    logic [STEP_W-1:0]   seq_step = '0;
    logic [TIME_W-1:0]   seq_deadline = '0;

    t_item               pending_beats[$];
    logic [MOTOR_W-1:0]  motor_expect[$];
    logic [TIME_W-1:0]   clock_now = '0;
    int unsigned         beats_planned = 0;
    int unsigned         fault_count = 0;
    int unsigned         src_gap = 0;
    int unsigned         sink_gap = 0;
    int unsigned         quiet_cycles = 0;

    timed_motion_step_sequencer_unit #(
        .TICKS_PER_SECOND(TICK_RATE)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_time_now     (i_time_now),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_motor_command(o_motor_command)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] step_ticks(input int unsigned ms);
        return (64'(ms) * 64'(TICK_RATE)) / 64'd1000;
    endfunction

    // Advance the predicted state by one accepted beat; queue any command it yields
    task automatic apply_beat(input t_item beat);
        logic [MOTOR_W-1:0] word;
        int unsigned        nxt;
        bit                 fired;
        fired = 1'b0;
        word  = '0;
        case (beat.cmd)
            CMD_START: begin
                if (seq_mode == MODE_STOPPED) seq_mode = MODE_START_REQ;
            end
            CMD_STOP: begin
                if (seq_mode == MODE_STARTED) seq_mode = MODE_STOP_REQ;
            end
            CMD_FOLD, CMD_UNFOLD: begin
                if (seq_mode == MODE_STOPPED) begin
                    seq_mode     = (beat.cmd == CMD_FOLD) ? MODE_FOLD : MODE_UNFOLD;
                    seq_step     = '0;
                    seq_deadline = '0;
                end
            end
            CMD_TICK: begin
                case (seq_mode)
                    MODE_START_REQ: begin
                        seq_step     = '0;
                        seq_deadline = '0;
                        seq_mode     = MODE_STARTED;
                    end
                    MODE_STARTED, MODE_STOP_REQ: begin
                        if (beat.time_now > seq_deadline) begin
                            nxt             = (seq_step + 1) % MAIN_STEPS;
                            seq_step        = STEP_W'(nxt);
                            seq_deadline    = beat.time_now + step_ticks(MAIN_STEP_MS[nxt]);
                            word            = MOTOR_W'(MAIN_STEP_DIR[nxt]);
                            word[LIGHT_BIT] = (seq_mode == MODE_STARTED);
                            fired           = 1'b1;
                        end
                        // stopping ends on step zero, with or without an advance
                        if (seq_mode == MODE_STOP_REQ && seq_step == 0) seq_mode = MODE_STOPPED;
                    end
                    MODE_FOLD: begin
                        if (beat.time_now > seq_deadline) begin
                            nxt          = (seq_step + 1) % FOLD_STEPS;
                            seq_step     = STEP_W'(nxt);
                            seq_deadline = beat.time_now + step_ticks(FOLD_STEP_MS[nxt]);
                            word         = MOTOR_W'(FOLD_STEP_DIR[nxt]);
                            fired        = 1'b1;
                            if (seq_step == 0) seq_mode = MODE_STOPPED;
                        end
                    end
                    MODE_UNFOLD: begin
                        if (beat.time_now > seq_deadline) begin
                            nxt          = (seq_step + 1) % UNFOLD_STEPS;
                            seq_step     = STEP_W'(nxt);
                            seq_deadline = beat.time_now + step_ticks(UNFOLD_STEP_MS[nxt]);
                            word         = MOTOR_W'(UNFOLD_STEP_DIR[nxt]);
                            fired        = 1'b1;
                            if (seq_step == 0) seq_mode = MODE_STOPPED;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (fired) motor_expect.push_back(word);
    endtask

    task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] stamp);
        pending_beats.push_back('{cmd: cmd, time_now: stamp});
        if (cmd <= CMD_UNFOLD) beats_planned++;
    endtask

    // Move the time base forward, mostly by amounts near a step length
    task automatic queue_tick();
        if ($urandom_range(0, 7) == 0) clock_now += $urandom_range(0, 3);
        else clock_now += $urandom_range(0, 170000);
        queue_beat(CMD_TICK, clock_now);
    endtask

    // Idle bursts only in banded stretches, never in the tail of the run
    function automatic bit idle_allowed();
        return pending_beats.size() >= TAIL_BEATS && ((pending_beats.size() / 64) % 3) != 0;
    endfunction

    // Stimulus, reset and end of run
    initial begin
        int unsigned pick;
        int unsigned n;
        // stopped: stop does nothing, spare codes ignored
        queue_beat(CMD_STOP, '0);
        queue_beat(3'(CMD_SPARE_LO), TIME_MAX);
        queue_beat(3'(CMD_SPARE_HI), TIME_MAX);
        // start, then a stop before any advance ends right away on step zero
        queue_beat(CMD_START, '0);
        queue_beat(CMD_FOLD, '0);
        queue_beat(CMD_TICK, '0);
        queue_beat(CMD_STOP, '0);
        queue_beat(CMD_TICK, '0);
        // full fold run, wrap to step zero stops it
        queue_beat(CMD_FOLD, '0);
        queue_beat(CMD_START, '0);
        queue_beat(CMD_TICK, 64'd1);
        for (int k = 40; k < 44; k++) queue_beat(CMD_TICK, 64'd1 << k);
        // full unfold run
        queue_beat(CMD_UNFOLD, '0);
        for (int k = 44; k < 48; k++) queue_beat(CMD_TICK, 64'd1 << k);
        // main loop at the top of the time range: deadline wraps, equal time holds
        queue_beat(CMD_START, '0);
        queue_beat(CMD_TICK, TIME_MAX);
        queue_beat(CMD_TICK, TIME_MAX);
        queue_beat(CMD_TICK, step_ticks(MAIN_STEP_MS[1]) - 64'd1);
        queue_beat(CMD_TICK, step_ticks(MAIN_STEP_MS[1]));
        queue_beat(CMD_STOP, '0);
        queue_beat(CMD_TICK, TIME_MAX);

        // random sessions, mostly well-formed runs
        while (beats_planned < RANDOM_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
                queue_beat(CMD_START, {$urandom, $urandom});
                queue_tick();
                n = $urandom_range(3, 30);
                repeat (n) queue_tick();
                queue_beat(CMD_STOP, {$urandom, $urandom});
                repeat (20) queue_tick();
            end else if (pick <= 6) begin
                queue_beat(CMD_FOLD, {$urandom, $urandom});
                repeat (8) queue_tick();
            end else if (pick == 7) begin
                queue_beat(CMD_UNFOLD, {$urandom, $urandom});
                repeat (7) queue_tick();
            end else if (pick == 8) begin
                repeat (10) begin
                    if ($urandom_range(0, 1) == 0) queue_beat(3'($urandom_range(0, 7)), clock_now);
                    else queue_beat(3'($urandom_range(0, 7)), {$urandom, $urandom});
                end
            end else begin
                // jump the time base, sometimes close to wrap
                if ($urandom_range(0, 1) == 0) clock_now = {$urandom, $urandom};
                else clock_now = TIME_MAX - 64'($urandom_range(0, 200000));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_valid) @(posedge i_clk);
        while (motor_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fault_count += motor_expect.size();
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Input side: predict each accepted beat, then present the next one or idle
    always @(posedge i_clk) begin : drive_beats
        t_item beat_out;
        if (i_rst_n) begin
            if (i_valid && !o_stall) apply_beat('{cmd: i_cmd, time_now: i_time_now});
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else begin
                    beat_out = pending_beats.pop_front();
                    i_cmd      <= beat_out.cmd;
                    i_time_now <= beat_out.time_now;
                    i_valid    <= 1'b1;
                end
            end
        end
    end

    // Output side: check each accepted beat, stall in random bursts
    always @(posedge i_clk) begin : check_commands
        logic [MOTOR_W-1:0] want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (motor_expect.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("unexpected motor command %05h", o_motor_command);
                end else begin
                    want = motor_expect.pop_front();
                    if (o_motor_command !== want) begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT)
                            $display("motor command mismatch: expected %05h, got %05h",
                                     want, o_motor_command);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_stall <= 1'b1;
            end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
